[rtl/kvs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Kinematic vehicle step package
// Shared widths, fixed-point constants, stage bundles and helper functions.
// ----------------------------------------------------------------------------
package kvs_pkg;

  localparam int DATA_W      = 32;
  localparam int DT_W        = 16;
  localparam int IWB_W       = 18;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 18;
  localparam int CW          = 34;
  localparam int RW          = 36;
  localparam int SUM_W       = 52;

  localparam logic [CFG_INDEX_W-1:0] REG_STEP_TIME     = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_INV_WHEELBASE = CFG_INDEX_W'(1);

  localparam logic [DT_W-1:0]  STEP_TIME_RST     = 16'd6554;
  localparam logic [IWB_W-1:0] INV_WHEELBASE_RST = 18'd24545;

  localparam logic signed [RW-1:0] PI_Q28      = 36'sd843314857;
  localparam logic signed [RW-1:0] TWO_PI_Q28  = 36'sd1686629713;
  localparam logic signed [RW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [RW-1:0] PI_Q30      = 36'sd3373259426;

  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30  = 34'sd1073741824;

  localparam logic signed [SUM_W-1:0] SAT_MAX = 52'sd2147483647;
  localparam logic signed [SUM_W-1:0] SAT_MIN = -52'sd2147483648;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    word_t pos_x;
    word_t pos_y;
    word_t heading;
    word_t speed;
    word_t steer;
    word_t accel;
    logic  flip;
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    side_t                side;
  } rot_t;

  typedef struct packed {
    word_t new_x;
    word_t new_y;
    word_t new_heading;
    word_t new_speed;
    logic  overflow;
  } res_t;

  // arctan(2^-i) in Q2.30, rounded
  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
    logic signed [CW-1:0] r;
    unique case (i)
      5'd0:    r = 34'sd843314857;
      5'd1:    r = 34'sd497837829;
      5'd2:    r = 34'sd263043837;
      5'd3:    r = 34'sd133525159;
      5'd4:    r = 34'sd67021687;
      5'd5:    r = 34'sd33543516;
      5'd6:    r = 34'sd16775851;
      5'd7:    r = 34'sd8388437;
      5'd8:    r = 34'sd4194283;
      5'd9:    r = 34'sd2097149;
      5'd10:   r = 34'sd1048576;
      5'd31:   r = 34'sd1;
      default: r = 34'sd1 <<< (5'd30 - i);
    endcase
    return r;
  endfunction

  // saturate to 32 bits, MSB of the result is the overflow flag
  function automatic logic [DATA_W:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [DATA_W:0] r;
    priority if (v > SAT_MAX) begin
      r = {1'b1, SAT_MAX[DATA_W-1:0]};
    end else if (v < SAT_MIN) begin
      r = {1'b1, SAT_MIN[DATA_W-1:0]};
    end else begin
      r = {1'b0, v[DATA_W-1:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/kvs_cordic_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC rotation cell
// One micro-rotation by arctan(2^-STAGE); passes the vehicle state along.
// ----------------------------------------------------------------------------
module kvs_cordic_cell
  import kvs_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  rot_t in_rot,
  output logic out_valid,
  output rot_t out_rot
);

  localparam logic [4:0] SHIFT = 5'(STAGE);

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] ang;
  rot_t                 rot_next;

  always_comb begin
    dx       = $signed(in_rot.y) >>> SHIFT;
    dy       = $signed(in_rot.x) >>> SHIFT;
    ang      = atan_q30(SHIFT);
    rot_next = in_rot;
    if (!in_rot.z[CW-1]) begin
      rot_next.x = $signed(in_rot.x) - dx;
      rot_next.y = $signed(in_rot.y) + dy;
      rot_next.z = $signed(in_rot.z) - ang;
    end else begin
      rot_next.x = $signed(in_rot.x) + dx;
      rot_next.y = $signed(in_rot.y) - dy;
      rot_next.z = $signed(in_rot.z) + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rot <= rot_next;
    end
  end

endmodule
`default_nettype wire

[rtl/kvs_kinematics.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Kinematic update pipeline
// Clamps cosine and sine, forms the scaled products and saturates the sums.
// ----------------------------------------------------------------------------
module kvs_kinematics
  import kvs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [DT_W-1:0]  dt,
  input  logic [IWB_W-1:0] iwb,
  input  logic             in_valid,
  input  rot_t             in_rot,
  output logic             out_valid,
  output res_t             out_res
);

  logic [3:0] vld;

  // post stage
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] sy;
  logic signed [CW-1:0] cx_clamp;
  logic signed [CW-1:0] sy_clamp;
  word_t                p_c;
  word_t                p_s;
  side_t                p_side;

  // first multiply stage
  logic signed [63:0] vc_full;
  logic signed [63:0] vs_full;
  logic signed [63:0] vst_full;
  logic signed [48:0] acc_full;
  logic signed [32:0] m1_vc;
  logic signed [32:0] m1_vs;
  logic signed [47:0] m1_vst;
  logic signed [32:0] m1_acc;
  side_t              m1_side;

  // second multiply stage
  logic signed [49:0] tx_full;
  logic signed [49:0] ty_full;
  logic signed [64:0] ph_full;
  logic signed [32:0] m2_tx;
  logic signed [32:0] m2_ty;
  logic signed [47:0] m2_ph;
  logic signed [32:0] m2_acc;
  side_t              m2_side;

  // third multiply stage
  logic signed [66:0] th_full;
  logic signed [50:0] m3_th;
  logic signed [32:0] m3_tx;
  logic signed [32:0] m3_ty;
  logic signed [32:0] m3_acc;
  side_t              m3_side;

  // final sums
  logic [DATA_W:0] sx;
  logic [DATA_W:0] sy_sat;
  logic [DATA_W:0] sh;
  logic [DATA_W:0] sv;
  res_t            res_next;

  logic signed [DT_W:0]  dt_s;
  logic signed [IWB_W:0] iwb_s;

  assign dt_s  = $signed({1'b0, dt});
  assign iwb_s = $signed({1'b0, iwb});

  always_comb begin
    cx = in_rot.side.flip ? -$signed(in_rot.x) : $signed(in_rot.x);
    sy = in_rot.side.flip ? -$signed(in_rot.y) : $signed(in_rot.y);
    priority if (cx > ONE_Q30) begin
      cx_clamp = ONE_Q30;
    end else if (cx < -ONE_Q30) begin
      cx_clamp = -ONE_Q30;
    end else begin
      cx_clamp = cx;
    end
    priority if (sy > ONE_Q30) begin
      sy_clamp = ONE_Q30;
    end else if (sy < -ONE_Q30) begin
      sy_clamp = -ONE_Q30;
    end else begin
      sy_clamp = sy;
    end
  end

  always_comb begin
    vc_full  = 64'($signed(p_side.speed)) * 64'($signed(p_c));
    vs_full  = 64'($signed(p_side.speed)) * 64'($signed(p_s));
    vst_full = 64'($signed(p_side.speed)) * 64'($signed(p_side.steer));
    acc_full = 49'($signed(p_side.accel)) * 49'(dt_s);
    tx_full  = 50'(m1_vc) * 50'(dt_s);
    ty_full  = 50'(m1_vs) * 50'(dt_s);
    ph_full  = 65'(m1_vst) * 65'(dt_s);
    th_full  = 67'(m2_ph) * 67'(iwb_s);
  end

  always_comb begin
    sx     = sat32(SUM_W'($signed(m3_side.pos_x)) + SUM_W'(m3_tx));
    sy_sat = sat32(SUM_W'($signed(m3_side.pos_y)) + SUM_W'(m3_ty));
    sh     = sat32(SUM_W'($signed(m3_side.heading)) + SUM_W'(m3_th));
    sv     = sat32(SUM_W'($signed(m3_side.speed)) + SUM_W'(m3_acc));
    res_next.new_x       = sx[DATA_W-1:0];
    res_next.new_y       = sy_sat[DATA_W-1:0];
    res_next.new_heading = sh[DATA_W-1:0];
    res_next.new_speed   = sv[DATA_W-1:0];
    res_next.overflow    = sx[DATA_W] | sy_sat[DATA_W] | sh[DATA_W] | sv[DATA_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[2:0], in_valid};
      out_valid <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_c     <= cx_clamp[DATA_W-1:0];
      p_s     <= sy_clamp[DATA_W-1:0];
      p_side  <= in_rot.side;

      m1_vc   <= vc_full[62:30];
      m1_vs   <= vs_full[62:30];
      m1_vst  <= vst_full[63:16];
      m1_acc  <= acc_full[48:16];
      m1_side <= p_side;

      m2_tx   <= tx_full[48:16];
      m2_ty   <= ty_full[48:16];
      m2_ph   <= ph_full[63:16];
      m2_acc  <= m1_acc;
      m2_side <= m1_side;

      m3_th   <= th_full[66:16];
      m3_tx   <= m2_tx;
      m3_ty   <= m2_ty;
      m3_acc  <= m2_acc;
      m3_side <= m2_side;

      out_res <= res_next;
    end
  end

endmodule
`default_nettype wire

[rtl/kinematic_vehicle_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Kinematic vehicle step
// Advances a bicycle-model vehicle state by one time step per transaction.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while in_stall is low; the pipeline
// of CORDIC cells and multiply stages advances in lockstep, and a two-entry
// output buffer absorbs a result held by out_stall before in_stall rises.
// Reset: rst clears all valid bits and loads step_time = 6554 and
// inv_wheelbase = 24545; the block accepts input in the cycle after reset.
module kinematic_vehicle_step
  import kvs_pkg::*;
#(
  parameter int CORDIC_STAGES = 26
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [31:0]     pos_x,
  input  logic signed [31:0]     pos_y,
  input  logic signed [31:0]     heading,
  input  logic signed [31:0]     speed,
  input  logic signed [31:0]     steer_angle,
  input  logic signed [31:0]     accel,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [31:0]     new_x,
  output logic signed [31:0]     new_y,
  output logic signed [31:0]     new_heading,
  output logic signed [31:0]     new_speed,
  output logic                   overflow,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [DT_W-1:0]  step_time;
  logic [IWB_W-1:0] inv_wheelbase;

  logic en;

  logic  s0_valid;
  side_t s0_side;

  logic signed [RW-1:0] h;
  logic signed [RW-1:0] hr;
  logic signed [RW-1:0] z4;
  logic signed [RW-1:0] zf;
  logic                 flip;
  rot_t                 rot_next;

  logic                   s1_valid;
  rot_t                   s1_rot;
  logic [CORDIC_STAGES:0] chain_valid;
  rot_t                   chain_rot [CORDIC_STAGES+1];

  logic fin_valid;
  res_t fin_res;

  logic out_free;
  logic skid_valid;
  res_t skid_res;
  res_t out_res;

  assign en        = !skid_valid;
  assign in_stall  = skid_valid;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time     <= STEP_TIME_RST;
      inv_wheelbase <= INV_WHEELBASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STEP_TIME:     step_time     <= cfg_data[DT_W-1:0];
        REG_INV_WHEELBASE: inv_wheelbase <= cfg_data[IWB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side.pos_x   <= pos_x;
      s0_side.pos_y   <= pos_y;
      s0_side.heading <= heading;
      s0_side.speed   <= speed;
      s0_side.steer   <= steer_angle;
      s0_side.accel   <= accel;
      s0_side.flip    <= 1'b0;
      s1_rot          <= rot_next;
    end
  end

  always_comb begin
    h = RW'($signed(s0_side.heading));
    priority if (h > PI_Q28) begin
      hr = h - TWO_PI_Q28;
    end else if (h < -PI_Q28) begin
      hr = h + TWO_PI_Q28;
    end else begin
      hr = h;
    end
    z4 = hr <<< 2;
    priority if (z4 > HALF_PI_Q30) begin
      zf   = z4 - PI_Q30;
      flip = 1'b1;
    end else if (z4 < -HALF_PI_Q30) begin
      zf   = z4 + PI_Q30;
      flip = 1'b1;
    end else begin
      zf   = z4;
      flip = 1'b0;
    end
    rot_next.x         = GAIN_Q30;
    rot_next.y         = '0;
    rot_next.z         = zf[CW-1:0];
    rot_next.side      = s0_side;
    rot_next.side.flip = flip;
  end

  assign chain_valid[0] = s1_valid;
  assign chain_rot[0]   = s1_rot;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    kvs_cordic_cell #(
      .STAGE(g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (chain_valid[g]),
      .in_rot   (chain_rot[g]),
      .out_valid(chain_valid[g+1]),
      .out_rot  (chain_rot[g+1])
    );
  end

  kvs_kinematics u_kinematics (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .dt       (step_time),
    .iwb      (inv_wheelbase),
    .in_valid (chain_valid[CORDIC_STAGES]),
    .in_rot   (chain_rot[CORDIC_STAGES]),
    .out_valid(fin_valid),
    .out_res  (fin_res)
  );

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= fin_valid;
      end
    end else if (fin_valid && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : fin_res;
    end
    if (!out_free && en) begin
      skid_res <= fin_res;
    end
  end

  assign new_x       = out_res.new_x;
  assign new_y       = out_res.new_y;
  assign new_heading = out_res.new_heading;
  assign new_speed   = out_res.new_speed;
  assign overflow    = out_res.overflow;

endmodule
`default_nettype wire

[rtl/kvs_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Kinematic vehicle step checker
// Port-level properties of the handshake and the output buffering.
// ----------------------------------------------------------------------------
module kvs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] new_x,
  input logic signed [31:0] new_y,
  input logic signed [31:0] new_heading,
  input logic signed [31:0] new_speed,
  input logic               overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(new_x) && $stable(new_y)
      && $stable(new_heading) && $stable(new_speed) && $stable(overflow))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && $past(out_valid && out_stall))
    else $error("input stalled without a held transaction");

endmodule

bind kinematic_vehicle_step kvs_checker u_checker (.*);
`default_nettype wire

[bench/kvs_step_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Kinematic vehicle step checker
// Watches the input, result and register channels of the vehicle step block.
// Each input transaction is turned into the expected next state by a
// bit-exact fixed-point predictor (heading reduction, CORDIC cos/sin,
// truncating products, saturating sums). Result transactions are compared
// field by field with the oldest expected state, in order.
// ----------------------------------------------------------------------------
module kvs_step_checker
  import kvs_pkg::*;
#(
  parameter int STAGES = 26
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  word_t                  pos_x,
  input  word_t                  pos_y,
  input  word_t                  heading,
  input  word_t                  speed,
  input  word_t                  steer_angle,
  input  word_t                  accel,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  word_t                  new_x,
  input  word_t                  new_y,
  input  word_t                  new_heading,
  input  word_t                  new_speed,
  input  logic                   overflow,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatch_count,
  output int                     results_owed
);

  localparam longint ANG_PI          = 843314857;
  localparam longint ANG_TWO_PI      = 1686629713;
  localparam longint ROT_HALF_PI     = 1686629713;
  localparam longint ROT_PI          = 64'sd3373259426;
  localparam longint ROT_QUARTER_PI  = 843314857;
  localparam longint ROT_GAIN        = 652032874;
  localparam longint ROT_ONE         = 1073741824;
  localparam longint WORD_MAX        = 2147483647;
  localparam longint WORD_MIN        = -64'sd2147483648;
  localparam logic [15:0] STEP_RESET = 16'd6554;
  localparam logic [17:0] IWB_RESET  = 18'd24545;

  longint      atan_tab [32];
  logic [15:0] dt_reg = STEP_RESET;
  logic [17:0] iwb_reg = IWB_RESET;
  res_t        next_states_owed [$];
  res_t        want;

  // arctan(2^-i) in Q2.30 from the alternating series evaluated in Q60
  function automatic longint arctan_pow2(input int i);
    longint acc;
    longint term;
    int     k;
    int     e;
    if (i == 0) return ROT_QUARTER_PI;
    acc = 0;
    k = 0;
    e = 60 - i;
    while (e >= 0) begin
      term = (longint'(1) << e) / longint'(2 * k + 1);
      if (k % 2 == 1) acc -= term;
      else acc += term;
      k++;
      e = 60 - i * (2 * k + 1);
    end
    return (acc + (longint'(1) << 29)) >>> 30;
  endfunction

  initial begin
    for (int k = 0; k < 32; k++) atan_tab[k] = arctan_pow2(k);
  end

  // floor(a * b / 2^16)
  function automatic longint scale_q16(input longint a, input logic [17:0] b);
    logic signed [95:0] p;
    p = a * $signed({1'b0, b});
    return longint'(p >>> 16);
  endfunction

  function automatic longint clamp_unit(input longint v);
    if (v > ROT_ONE) return ROT_ONE;
    if (v < -ROT_ONE) return -ROT_ONE;
    return v;
  endfunction

  // saturated word with the saturation flag on top
  function automatic logic [32:0] clip32(input longint v);
    if (v > WORD_MAX) return {1'b1, 32'h7FFF_FFFF};
    if (v < WORD_MIN) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  function automatic res_t advance_vehicle(
    input word_t px, input word_t py, input word_t hd, input word_t sp,
    input word_t st, input word_t ac, input logic [15:0] dt, input logic [17:0] iwb
  );
    longint      ang;
    longint      z;
    longint      cx;
    longint      sy;
    longint      dx;
    longint      dy;
    longint      t;
    logic [32:0] clipped;
    logic        flip;
    logic        ovf;
    res_t        r;
    ang = hd;
    while (ang > ANG_PI) ang -= ANG_TWO_PI;
    while (ang < -ANG_PI) ang += ANG_TWO_PI;
    z = ang * 4;
    flip = 1'b0;
    if (z > ROT_HALF_PI) begin
      z -= ROT_PI;
      flip = 1'b1;
    end else if (z < -ROT_HALF_PI) begin
      z += ROT_PI;
      flip = 1'b1;
    end
    cx = ROT_GAIN;
    sy = 0;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = sy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx -= dx;
        sy += dy;
        z -= atan_tab[i];
      end else begin
        cx += dx;
        sy -= dy;
        z += atan_tab[i];
      end
    end
    if (flip) begin
      cx = -cx;
      sy = -sy;
    end
    cx = clamp_unit(cx);
    sy = clamp_unit(sy);

    t = scale_q16((longint'(sp) * cx) >>> 30, {2'b00, dt});
    clipped = clip32(longint'(px) + t);
    r.new_x = clipped[31:0];
    ovf = clipped[32];

    t = scale_q16((longint'(sp) * sy) >>> 30, {2'b00, dt});
    clipped = clip32(longint'(py) + t);
    r.new_y = clipped[31:0];
    ovf |= clipped[32];

    t = scale_q16(scale_q16((longint'(sp) * longint'(st)) >>> 16, {2'b00, dt}), iwb);
    clipped = clip32(longint'(hd) + t);
    r.new_heading = clipped[31:0];
    ovf |= clipped[32];

    t = scale_q16(longint'(ac), {2'b00, dt});
    clipped = clip32(longint'(sp) + t);
    r.new_speed = clipped[31:0];
    ovf |= clipped[32];

    r.overflow = ovf;
    return r;
  endfunction

  task automatic check_field(input string label, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h, actual %h", $time, label, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dt_reg = STEP_RESET;
      iwb_reg = IWB_RESET;
      next_states_owed.delete();
      mismatch_count = 0;
      results_owed <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        next_states_owed.push_back(advance_vehicle(pos_x, pos_y, heading, speed,
                                                   steer_angle, accel, dt_reg, iwb_reg));
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_STEP_TIME) dt_reg = cfg_data[15:0];
        else if (cfg_index == REG_INV_WHEELBASE) iwb_reg = cfg_data[17:0];
      end
      if (out_valid && !out_stall) begin
        if (next_states_owed.size() == 0) begin
          $display("%0t: result expected none, actual %h %h %h %h %b", $time,
                   new_x, new_y, new_heading, new_speed, overflow);
          mismatch_count++;
        end else begin
          want = next_states_owed.pop_front();
          check_field("new_x", want.new_x, new_x);
          check_field("new_y", want.new_y, new_y);
          check_field("new_heading", want.new_heading, new_heading);
          check_field("new_speed", want.new_speed, new_speed);
          check_field("overflow", 32'(want.overflow), 32'(overflow));
        end
      end
      results_owed <= next_states_owed.size();
    end
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Kinematic vehicle step testbench
// Drives vehicle states through the step block under several register
// settings (reset values, zero and full-scale step time and wheelbase
// reciprocal), with directed corner states followed by random ones, and
// random idle bursts on both channels. The checker predicts and compares;
// this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import kvs_pkg::*;

  localparam int STAGES       = 26;
  localparam int PHASE_ITEMS  = 85;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 2 * (STAGES + 8);

  typedef struct packed {
    word_t pos_x;
    word_t pos_y;
    word_t heading;
    word_t speed;
    word_t steer;
    word_t accel;
  } vehicle_in_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  word_t                  pos_x = '0;
  word_t                  pos_y = '0;
  word_t                  heading = '0;
  word_t                  speed = '0;
  word_t                  steer_angle = '0;
  word_t                  accel = '0;
  logic                   out_stall = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_stall;
  logic                   out_valid;
  word_t                  new_x;
  word_t                  new_y;
  word_t                  new_heading;
  word_t                  new_speed;
  logic                   overflow;
  logic                   cfg_ready;
  int                     mismatch_count;
  int                     results_owed;
  int                     idle_cycles = 0;
  int                     gap_pct = 0;
  int                     stall_pct = 0;
  logic                   calm = 1'b0;

  always #1 clk = ~clk;

  kinematic_vehicle_step #(.CORDIC_STAGES(STAGES)) uut (.*);

  kvs_step_checker #(.STAGES(STAGES)) u_step_checker (.*);

  function automatic word_t wild_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic word_t spread(input int unsigned half);
    return word_t'($urandom_range(0, 2 * half)) - word_t'(half);
  endfunction

  function automatic vehicle_in_t make_state(input word_t px, input word_t py,
                                             input word_t hd, input word_t sp,
                                             input word_t st, input word_t ac);
    return '{pos_x: px, pos_y: py, heading: hd, speed: sp, steer: st, accel: ac};
  endfunction

  function automatic vehicle_in_t random_state();
    vehicle_in_t v;
    v.pos_x   = spread(1000 << 16);
    v.pos_y   = spread(1000 << 16);
    v.heading = spread(32'd1073741824);
    v.speed   = spread(40 << 16);
    v.steer   = spread(32'd161061273);
    v.accel   = spread(6 << 16);
    if ($urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 1) == 1) v.pos_x = wild_word();
      if ($urandom_range(0, 1) == 1) v.pos_y = wild_word();
      if ($urandom_range(0, 1) == 1) v.heading = wild_word();
      if ($urandom_range(0, 1) == 1) v.speed = wild_word();
      if ($urandom_range(0, 1) == 1) v.steer = wild_word();
      if ($urandom_range(0, 1) == 1) v.accel = wild_word();
    end
    return v;
  endfunction

  task automatic pick_idling();
    gap_pct = calm ? 0 : 20 * $urandom_range(0, 3);
    stall_pct = calm ? 0 : 20 * $urandom_range(0, 3);
  endtask

  task automatic send_state(input vehicle_in_t v);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pos_x       <= v.pos_x;
    pos_y       <= v.pos_y;
    heading     <= v.heading;
    speed       <= v.speed;
    steer_angle <= v.steer;
    accel       <= v.accel;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 25 == 0) pick_idling();
      send_state(random_state());
    end
    in_valid <= 1'b0;
  endtask

  task automatic config_phase(input logic [CFG_DATA_W-1:0] dt_word,
                              input logic [CFG_DATA_W-1:0] iwb_word);
    write_reg(REG_STEP_TIME, dt_word);
    write_reg(REG_INV_WHEELBASE, iwb_word);
    if ($urandom_range(0, 1) == 1) begin
      write_reg(CFG_INDEX_W'($urandom_range(REG_INV_WHEELBASE + 1, (1 << CFG_INDEX_W) - 1)),
                CFG_DATA_W'($urandom));
    end
    run_random(PHASE_ITEMS);
  endtask

  // result channel back-pressure
  always begin
    @(posedge clk);
    if (!rst && $urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // corner states under reset register values
    send_state(make_state(0, 0, 0, 0, 0, 0));
    send_state(make_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_state(make_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000));
    send_state(make_state('1, '1, '1, '1, '1, '1));
    send_state(make_state(0, 0, 843314857, 10 << 16, 0, 0));
    send_state(make_state(0, 0, -843314857, 10 << 16, 0, 0));
    send_state(make_state(0, 0, 843314858, 10 << 16, 0, 0));
    send_state(make_state(0, 0, -843314858, 10 << 16, 0, 0));
    send_state(make_state(0, 0, 32'h7FFF_FFFF, 5 << 16, 1 << 26, 0));
    send_state(make_state(0, 0, 32'h8000_0000, 5 << 16, -(1 << 26), 0));
    send_state(make_state(0, 0, 421657428, 20 << 16, 0, 0));
    send_state(make_state(0, 0, 421657429, 20 << 16, 0, 0));
    send_state(make_state(0, 0, -421657428, 20 << 16, 0, 0));
    send_state(make_state(0, 0, -421657429, 20 << 16, 0, 0));
    send_state(make_state(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 0));
    send_state(make_state(0, 32'h8000_0000, -421657428, 32'h7FFF_FFFF, 0, 0));
    send_state(make_state(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    send_state(make_state(0, 0, 0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF));
    send_state(make_state(0, 0, 0, 32'h8000_0000, 0, 32'h8000_0000));
    run_random(PHASE_ITEMS);

    config_phase(18'h0_0000, 18'h3_FFFF);
    config_phase(18'h0_FFFF, 18'h0_0000);
    config_phase(18'h0_FFFF, 18'h3_FFFF);
    config_phase(18'h3_0001, 18'h0_0001);
    config_phase(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
    calm = 1'b1;
    config_phase(18'd6554, 18'd24545);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[kinematic_vehicle_step.f]
rtl/kvs_pkg.sv
rtl/kvs_cordic_cell.sv
rtl/kvs_kinematics.sv
rtl/kinematic_vehicle_step.sv
rtl/kvs_checker.sv
bench/kvs_step_checker.sv
bench/tb.sv
